[src/assert_macros.svh]
// Assertion macros used by the checker file of the mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, held off during reset.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/slbm_pkg.sv]
// Types and constants of the serial-loaded bank mapper.
package slbm_pkg;

  // bus commands
  localparam logic [1:0] CMD_CPU_RD = 2'd0;
  localparam logic [1:0] CMD_CPU_WR = 2'd1;
  localparam logic [1:0] CMD_PPU_RD = 2'd2;
  localparam logic [1:0] CMD_PPU_WR = 2'd3;

  // result targets
  localparam logic [2:0] TGT_NONE = 3'd0;
  localparam logic [2:0] TGT_WRAM = 3'd1;
  localparam logic [2:0] TGT_PRG  = 3'd2;
  localparam logic [2:0] TGT_CHR  = 3'd3;
  localparam logic [2:0] TGT_NT   = 3'd4;

  // pattern memory kinds
  localparam logic [1:0] CHR_NONE = 2'd0;
  localparam logic [1:0] CHR_RAM  = 2'd1;
  localparam logic [1:0] CHR_ROM  = 2'd2;

  // mirroring, control bits 1:0
  localparam logic [1:0] MIR_ONE_LO = 2'd0;
  localparam logic [1:0] MIR_ONE_HI = 2'd1;
  localparam logic [1:0] MIR_VERT   = 2'd2;
  localparam logic [1:0] MIR_HORZ   = 2'd3;

  // program bank mode, control bits 3:2
  localparam logic [1:0] PRG_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_FIX_LAST  = 2'd3;

  // serial register targets, address bits 14:13
  localparam logic [1:0] SEL_CTRL = 2'd0;
  localparam logic [1:0] SEL_CHR0 = 2'd1;
  localparam logic [1:0] SEL_CHR1 = 2'd2;
  localparam logic [1:0] SEL_PRG  = 2'd3;

  // configuration register indexes
  localparam logic REG_PRG_COUNT = 1'b0;
  localparam logic REG_CHR_KIND  = 1'b1;

  localparam logic [4:0] MODE_RESET     = 5'h1C;
  localparam logic [4:0] MODE_RESET_SET = 5'h0C;
  localparam logic [2:0] SHIFT_LAST     = 3'd4;
  localparam logic [4:0] PRG_COUNT_RST  = 5'd16;

  localparam int NT_BYTES = 2048;
  localparam int NT_AW    = $clog2(NT_BYTES);

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } in_t;

  typedef struct packed {
    logic        claimed;
    logic [2:0]  target;
    logic [18:0] mem_address;
    logic        mem_write;
    logic [7:0]  read_data;
  } out_t;

  typedef struct packed {
    logic [4:0] shift_value;
    logic [2:0] shift_count;
    logic [4:0] mode_bits;
    logic [4:0] bank_lo;
    logic [4:0] bank_hi;
    logic [4:0] prg_bank;
  } map_state_t;

  typedef struct packed {
    logic [4:0] prg_bank_count;
    logic [1:0] chr_kind;
  } cfg_t;

  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [NT_AW-1:0] idx;
  } nt_req_t;

endpackage

[src/slbm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module slbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/slbm_xlate.sv]
// Address translation and serial register update for one bus access.
module slbm_xlate import slbm_pkg::*; (
  input  in_t        acc,
  input  map_state_t st,
  input  cfg_t       cfg,
  output out_t       res,
  output map_state_t st_nxt,
  output nt_req_t    nt
);

  logic        wr;
  logic [15:0] a;
  logic [13:0] pa;
  logic [4:0]  last_bank;
  logic [18:0] prg_addr;
  logic [18:0] chr_addr;
  logic [4:0]  shifted;
  logic [2:0]  cnt_inc;
  logic        nt_page;

  assign wr        = acc.command[0];
  assign a         = acc.bus_address;
  assign pa        = a[13:0];
  assign last_bank = cfg.prg_bank_count - 5'd1;
  assign shifted   = {acc.write_data[0], st.shift_value[4:1]};
  assign cnt_inc   = st.shift_count + 3'd1;

  always_comb begin
    case (st.mode_bits[3:2])
      PRG_FIX_FIRST: prg_addr = a[14] ? {1'b0, st.prg_bank[3:0], a[13:0]}
                                      : {5'd0, a[13:0]};
      PRG_FIX_LAST:  prg_addr = a[14] ? {last_bank, a[13:0]}
                                      : {1'b0, st.prg_bank[3:0], a[13:0]};
      default:       prg_addr = {1'b0, st.prg_bank[3:1], a[14:0]};
    endcase
  end

  always_comb begin
    if (cfg.chr_kind == CHR_RAM) begin
      chr_addr = {6'd0, pa[12:0]};
    end else if (st.mode_bits[4]) begin
      chr_addr = pa[12] ? {2'd0, st.bank_hi, pa[11:0]} : {2'd0, st.bank_lo, pa[11:0]};
    end else begin
      chr_addr = {2'd0, st.bank_lo[4:1], pa[12:0]};
    end
  end

  always_comb begin
    case (st.mode_bits[1:0])
      MIR_ONE_LO: nt_page = 1'b0;
      MIR_ONE_HI: nt_page = 1'b1;
      MIR_VERT:   nt_page = pa[10];
      default:    nt_page = pa[11];
    endcase
  end

  always_comb begin
    res    = '0;
    st_nxt = st;
    nt     = '0;
    nt.idx = {nt_page, pa[9:0]};
    if (!acc.command[1]) begin
      if (a[15:13] == 3'b011) begin
        res.claimed     = 1'b1;
        res.target      = TGT_WRAM;
        res.mem_address = {6'd0, a[12:0]};
        res.mem_write   = wr;
      end else if (a[15]) begin
        res.claimed = 1'b1;
        if (wr) begin
          if (acc.write_data[7]) begin
            st_nxt.shift_value = '0;
            st_nxt.shift_count = '0;
            st_nxt.mode_bits   = st.mode_bits | MODE_RESET_SET;
          end else if (st.shift_count == SHIFT_LAST) begin
            // fifth bit: commit to the register picked by the address
            st_nxt.shift_value = '0;
            st_nxt.shift_count = '0;
            unique case (a[14:13])
              SEL_CTRL: st_nxt.mode_bits = shifted;
              SEL_CHR0: st_nxt.bank_lo   = shifted;
              SEL_CHR1: st_nxt.bank_hi   = shifted;
              SEL_PRG:  st_nxt.prg_bank  = shifted;
              default:  st_nxt.prg_bank  = shifted;
            endcase
          end else begin
            st_nxt.shift_value = shifted;
            st_nxt.shift_count = cnt_inc;
          end
        end else begin
          res.target      = TGT_PRG;
          res.mem_address = prg_addr;
        end
      end
    end else if (!pa[13]) begin
      if (cfg.chr_kind != CHR_NONE) begin
        res.claimed     = 1'b1;
        res.target      = TGT_CHR;
        res.mem_address = chr_addr;
        res.mem_write   = wr && (cfg.chr_kind == CHR_RAM);
      end
    end else if (pa[13:8] != 6'h3F) begin
      res.claimed     = 1'b1;
      res.target      = TGT_NT;
      res.mem_address = {{(19-NT_AW){1'b0}}, nt.idx};
      nt.rd           = !wr;
      nt.wr           = wr;
    end
  end

endmodule

[src/serial_loaded_bank_mapper.sv]
// Top level of the serial-loaded cartridge bank mapper.
// One CPU or PPU bus access is taken per cycle while in_stall is low and gives
// one result beat. The accepting cycle decodes the access, updates the serial
// mapper registers and issues the nametable RAM access; the result waits in
// stage one while the output is stalled, then moves into the output register
// with the registered RAM read data. The rate of one access per cycle is set
// by the nametable RAM, which takes one write and one read per cycle; a write
// lands before any later read of the same entry, so no forwarding is needed.
// After reset the block sweeps the 2048-byte nametable to zero, one byte a
// cycle, and holds in_stall high meanwhile; configuration writes are taken throughout.
module serial_loaded_bank_mapper import slbm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t             cfg_r;
  map_state_t       st_r;
  map_state_t       st_nxt;
  out_t             res;
  nt_req_t          nt;
  logic             accept;
  logic             s1_valid_r;
  out_t             s1_res_r;
  logic             s1_rd_r;
  logic             s1_move;
  logic             out_valid_r;
  out_t             out_data_r;
  out_t             out_data_nxt;
  logic             clr_active_r;
  logic [NT_AW-1:0] clr_addr_r;
  logic             ram_we;
  logic [NT_AW-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CHR_KIND) ? {30'd0, cfg_r.chr_kind}
                                             : {27'd0, cfg_r.prg_bank_count};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prg_bank_count <= PRG_COUNT_RST;
      cfg_r.chr_kind       <= CHR_ROM;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_PRG_COUNT: cfg_r.prg_bank_count <= pwdata[4:0];
        REG_CHR_KIND:  cfg_r.chr_kind       <= pwdata[1:0];
        default:       cfg_r.chr_kind       <= pwdata[1:0];
      endcase
    end
  end

  slbm_xlate u_xlate (
    .acc    (in_data),
    .st     (st_r),
    .cfg    (cfg_r),
    .res    (res),
    .st_nxt (st_nxt),
    .nt     (nt)
  );

  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clr_active_r || (s1_valid_r && !s1_move);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.shift_value <= '0;
      st_r.shift_count <= '0;
      st_r.mode_bits   <= MODE_RESET;
      st_r.bank_lo     <= '0;
      st_r.bank_hi     <= '0;
      st_r.prg_bank    <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  // clear the nametable after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (&clr_addr_r) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  assign ram_we    = clr_active_r || (accept && nt.wr);
  assign ram_waddr = clr_active_r ? clr_addr_r : nt.idx;
  assign ram_wdata = clr_active_r ? 8'd0 : in_data.write_data;

  slbm_ram #(
    .WIDTH (8),
    .DEPTH (NT_BYTES)
  ) u_nt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept && nt.rd),
    .raddr (nt.idx),
    .rdata (ram_rdata)
  );

  // read data holds while stage one waits, since no new read is issued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept || (s1_valid_r && !s1_move);
      out_valid_r <= s1_move || (out_valid_r && out_stall);
    end
  end

  always_comb begin
    out_data_nxt           = s1_res_r;
    out_data_nxt.read_data = s1_rd_r ? ram_rdata : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r <= res;
      s1_rd_r  <= nt.rd;
    end
    if (s1_move) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/slbm_checker.sv]
// Port-level checker for the bank mapper, bound to the top level.
`include "assert_macros.svh"

module slbm_checker import slbm_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  logic out_hold;
  logic unclaimed_clean;
  logic write_target_ok;
  logic nt_addr_ok;
  logic rdata_nz;

  assign out_hold        = out_valid && out_stall;
  assign unclaimed_clean = (out_data.target == TGT_NONE) && (out_data.mem_address == '0)
                           && !out_data.mem_write && (out_data.read_data == 8'd0);
  assign write_target_ok = (out_data.target == TGT_WRAM) || (out_data.target == TGT_CHR);
  assign nt_addr_ok      = (out_data.mem_address[18:NT_AW] == '0) && !out_data.mem_write;
  assign rdata_nz        = out_valid && (out_data.read_data != 8'd0);

  `ASSERT_NXT(a_out_held, out_hold, out_valid && $stable(out_data))
  `ASSERT_IMP(a_unclaimed_zero, out_valid && !out_data.claimed, unclaimed_clean)
  `ASSERT_IMP(a_ext_write_target, out_valid && out_data.mem_write, write_target_ok)
  `ASSERT_IMP(a_nt_in_range, out_valid && (out_data.target == TGT_NT), nt_addr_ok)
  `ASSERT_IMP(a_rdata_nt_only, rdata_nz, out_data.target == TGT_NT)

endmodule

bind serial_loaded_bank_mapper slbm_checker u_slbm_checker (.*);
